>>> hw/rtl/uer_pkg.sv
// Shared types, codes and constants for the ultrasonic echo ranger.
package uer_pkg;

  // Default distance fraction bits (distance in 1/2^n cm)
  localparam int FRACTION_BITS_DEF = 4;
  // Microseconds of round trip per centimetre
  localparam int SOUND_DIVISOR     = 58;

  localparam int TICK_W   = 16;
  localparam int DIST_W   = 14;
  localparam int DIST_MAX = 16383;
  localparam int ALPHA_W  = 8;
  localparam int CFG_DW   = 16;
  localparam int CFG_AW   = 2;

  // Register reset values
  localparam logic [7:0]  TRIG_LOW_RST  = 8'd5;
  localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;
  localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
  localparam logic [7:0]  ALPHA_RST     = 8'd102;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_t;

  typedef enum logic [1:0] {
    ST_VALID,
    ST_NO_RISE,
    ST_TOO_LONG,
    ST_ZERO_WIDTH
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TRIG_LOW,
    CFG_TRIG_HIGH,
    CFG_TIMEOUT,
    CFG_ALPHA
  } cfg_idx_t;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } in_beat_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] raw_distance;
    logic [DIST_W-1:0] filtered_distance;
    logic              filtered_valid;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]         trigger_low_ticks;
    logic [7:0]         trigger_high_ticks;
    logic [TICK_W-1:0]  timeout_ticks;
    logic [ALPHA_W-1:0] filter_alpha;
  } cfg_t;

endpackage

>>> hw/rtl/ultrasonic_echo_ranger_filtered_top.sv
// Top level of the ultrasonic echo ranger with smoothing filter.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | one microsecond tick
//   output  | out_valid, out_stall, out_data | one result per input tick
//   config  | cfg_we, cfg_index, cfg_wdata   | one register write
//
// A tick passes an input register, then the sequencer and filter logic, and
// lands in the output register; one tick per cycle while the output is not stalled.
// The filter multiply and the distance saturation set the critical path.
// Reset is synchronous; it clears phase, counters, filter and the valids.
// A stalled output holds its beat; the input register then fills and stalls.
module ultrasonic_echo_ranger_filtered_top
  import uer_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic      in_valid_r;
  in_beat_t  in_data_r;
  logic      out_valid_r;
  out_beat_t out_data_r;
  out_beat_t res;
  cfg_t      cfg;
  logic      advance;
  logic      in_take;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_core #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .in_beat (in_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Handshake: a held beat moves on when the output slot is free
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/uer_cfg_regs.sv
// Configuration register file for the echo ranger.
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIG_LOW:  cfg_nxt.trigger_low_ticks  = cfg_wdata[7:0];
        CFG_TRIG_HIGH: cfg_nxt.trigger_high_ticks = cfg_wdata[7:0];
        CFG_TIMEOUT:   cfg_nxt.timeout_ticks      = cfg_wdata[TICK_W-1:0];
        CFG_ALPHA:     cfg_nxt.filter_alpha       = cfg_wdata[ALPHA_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_low_ticks  <= TRIG_LOW_RST;
      cfg_r.trigger_high_ticks <= TRIG_HIGH_RST;
      cfg_r.timeout_ticks      <= TIMEOUT_RST;
      cfg_r.filter_alpha       <= ALPHA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/uer_filter.sv
// Exponential smoothing step: old + alpha*(sample-old), Q8 weight, rounded.
module uer_filter
  import uer_pkg::*;
(
  input  logic [DIST_W-1:0]  sample,
  input  logic [DIST_W-1:0]  old_value,
  input  logic               seeded,
  input  logic [ALPHA_W-1:0] alpha,
  output logic [DIST_W-1:0]  new_value
);

  localparam int DIFF_W = DIST_W + 1;
  localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
  localparam int ACC_W  = PROD_W + 1;

  logic        [DIST_W-1:0] base;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // An unseeded filter takes the sample itself as the old value
  assign base = seeded ? old_value : sample;
  assign diff = $signed({1'b0, sample}) - $signed({1'b0, base});
  assign prod = $signed({1'b0, alpha}) * diff;
  assign acc  = $signed({{(ACC_W-DIST_W-8){1'b0}}, base, 8'd0})
              + ACC_W'(prod) + ACC_W'(128);

  // Result is never negative; keep the low distance bits
  assign new_value = acc[DIST_W+7:8];

endmodule

>>> hw/rtl/uer_core.sv
// Measurement sequencer, running width-to-distance quotient and filter state.
module uer_core
  import uer_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_beat_t  in_beat,
  input  cfg_t      cfg,
  output out_beat_t res
);

  // Distance = round((width << FRACTION_BITS) / SOUND_DIVISOR), kept as a
  // quotient and remainder that advance with the width counter.
  localparam int STEP   = 1 << FRACTION_BITS;
  localparam int STEP_Q = STEP / SOUND_DIVISOR;
  localparam int STEP_R = STEP % SOUND_DIVISOR;
  localparam int HALF   = SOUND_DIVISOR / 2;
  localparam int QMAX   = ((65535 << FRACTION_BITS) + HALF) / SOUND_DIVISOR;
  localparam int QW     = $clog2(QMAX + 1);
  localparam int RW     = $clog2(SOUND_DIVISOR);
  localparam int CW     = (QW > DIST_W) ? QW : DIST_W + 1;

  phase_t             phase_r, phase_nxt, ph;
  logic [TICK_W-1:0]  tick_r, tick_nxt, tk;
  logic [QW-1:0]      quo_r, quo_nxt, quo_step;
  logic [RW-1:0]      rem_r, rem_nxt, rem_step;
  logic [DIST_W-1:0]  filt_r, filt_nxt, filt_new;
  logic               seeded_r, seeded_nxt;

  logic [TICK_W:0]    tick_inc;
  logic [RW:0]        rem_sum;
  logic               rem_carry;
  logic [CW-1:0]      quo_ext;
  logic [DIST_W-1:0]  dist_sat;
  logic [7:0]         hi_ticks;
  logic               filt_en;

  // Running quotient step
  assign rem_sum   = (RW+1)'(rem_r) + (RW+1)'(STEP_R);
  assign rem_carry = rem_sum >= (RW+1)'(SOUND_DIVISOR);
  assign rem_step  = rem_carry ? RW'(rem_sum - (RW+1)'(SOUND_DIVISOR)) : RW'(rem_sum);
  assign quo_step  = quo_r + QW'(STEP_Q) + QW'(rem_carry);

  // Saturate to the distance range
  assign quo_ext  = CW'(quo_r);
  assign dist_sat = (quo_ext > CW'(DIST_MAX)) ? {DIST_W{1'b1}} : quo_ext[DIST_W-1:0];

  assign hi_ticks = (cfg.trigger_high_ticks == 8'd0) ? 8'd1 : cfg.trigger_high_ticks;

  uer_filter u_filter (
    .sample    (dist_sat),
    .old_value (filt_r),
    .seeded    (seeded_r),
    .alpha     (cfg.filter_alpha),
    .new_value (filt_new)
  );

  // Start decode ahead of the phase work
  always_comb begin
    ph = phase_r;
    tk = tick_r;
    if (phase_r == PH_IDLE && in_beat.start_request) begin
      tk = '0;
      ph = (cfg.trigger_low_ticks == 8'd0) ? PH_TRIG_HIGH : PH_TRIG_LOW;
    end
  end

  assign tick_inc = {1'b0, tk} + (TICK_W+1)'(1);

  // Next state
  always_comb begin
    phase_nxt = ph;
    tick_nxt  = tk;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    unique case (ph)
      PH_IDLE: ;
      PH_TRIG_LOW: begin
        if (tick_inc >= (TICK_W+1)'(cfg.trigger_low_ticks)) begin
          phase_nxt = PH_TRIG_HIGH;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_TRIG_HIGH: begin
        if (tick_inc >= (TICK_W+1)'(hi_ticks)) begin
          phase_nxt = PH_WAIT_RISE;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_WAIT_RISE: begin
        if (in_beat.echo_level) begin
          phase_nxt = PH_MEASURE;
          tick_nxt  = '0;
          quo_nxt   = '0;
          rem_nxt   = RW'(HALF);
        end else if (tk >= cfg.timeout_ticks) begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[TICK_W-1:0];
        end
      end
      PH_MEASURE: begin
        if (in_beat.echo_level && tk < cfg.timeout_ticks) begin
          tick_nxt = tick_inc[TICK_W-1:0];
          quo_nxt  = quo_step;
          rem_nxt  = rem_step;
        end else begin
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  // Result fields
  always_comb begin
    res         = '0;
    filt_en     = 1'b0;
    res.busy_res = (ph != PH_IDLE);
    unique case (ph)
      PH_IDLE, PH_TRIG_LOW: ;
      PH_TRIG_HIGH: res.trigger_level = 1'b1;
      PH_WAIT_RISE: begin
        if (!in_beat.echo_level && tk >= cfg.timeout_ticks) begin
          res.done_res = 1'b1;
          res.status   = ST_NO_RISE;
        end
      end
      PH_MEASURE: begin
        if (in_beat.echo_level) begin
          if (tk >= cfg.timeout_ticks) begin
            res.done_res = 1'b1;
            res.status   = ST_TOO_LONG;
          end
        end else begin
          res.done_res = 1'b1;
          if (tk == '0) begin
            res.status = ST_ZERO_WIDTH;
          end else begin
            res.status       = ST_VALID;
            res.raw_distance = dist_sat;
            filt_en          = 1'b1;
          end
        end
      end
      default: ;
    endcase
    filt_nxt   = filt_en ? filt_new : filt_r;
    seeded_nxt = seeded_r | filt_en;
    res.filtered_distance = filt_nxt;
    res.filtered_valid    = seeded_nxt;
  end

  // State registers, advanced once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      filt_r   <= '0;
      seeded_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      filt_r   <= filt_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  // Quotient and remainder are loaded on echo rise before use
  always_ff @(posedge clk) begin
    if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Once seeded the filter stays seeded
  a_seed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r) else $error("filter seed lost");

  // Idle without a start request stays idle
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_IDLE && !in_beat.start_request |=> phase_r == PH_IDLE)
    else $error("left idle without start");

  // A distance appears only on a valid finish
  a_raw_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res.raw_distance != '0 |-> res.done_res && res.status == ST_VALID)
    else $error("distance on a non-valid beat");

  // Remainder stays below the divisor while timing the echo
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MEASURE |-> rem_r < RW'(SOUND_DIVISOR))
    else $error("distance remainder out of range");

endmodule
